@@ rtl/hrsp_pkg.sv @@
// shared types, character codes and hex digit decode for the hex record parser
package hrsp_pkg;

    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    typedef enum logic [5:0] {
        PH_COLON = 6'b000001,
        PH_COUNT = 6'b000010,
        PH_ADDR  = 6'b000100,
        PH_TYPE  = 6'b001000,
        PH_DATA  = 6'b010000,
        PH_SKIP  = 6'b100000
    } phase_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] ch);
        hex_digit_t d;
        d.ok  = 1'b1;
        d.nib = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            d.nib = 4'(ch - 8'h30);
        end
        else if (ch >= 8'h41 && ch <= 8'h46)
        begin
            d.nib = 4'(ch - 8'h37);
        end
        else if (ch >= 8'h61 && ch <= 8'h66)
        begin
            d.nib = 4'(ch - 8'h57);
        end
        else
        begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

@@ rtl/hex_record_stream_parser_top.sv @@
// hex record stream parser: one character in, at most one data/end/error result out
//
// Usage: the s_ channel takes one ASCII character of an Intel HEX text per
// transfer (s_tdata). Each record is ':', a two-digit byte count, a four-digit
// load address and a two-digit type. Data records give one m_ transfer per
// data byte, with its address, value and the running byte total in m_tdata
// and kind 0 in m_tuser. The checksum and the rest of the line up to newline
// are skipped. Any other record type gives one end result (kind 1); a missing
// colon or a bad hex digit gives one error result (kind 2). After either the
// block drops every further character until reset.
// A character accepted into the input register is decoded and its result is
// written to the output register. Throughput: one character per cycle unless
// m_tready stalls, set by the single decode step between input and output registers.
// Reset clears all parser state and both valid flags; no pass is needed.
// A stalled m_tready holds the result; the input register still takes one
// more character if empty, and s_tready then drops until the result is taken.
module hex_record_stream_parser_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // byte_address[15:0], byte_value[23:16], total_bytes[39:24]
    output logic [1:0]  m_tuser    // kind
);

    logic                 in_valid_reg;
    logic [7:0]           in_char_reg;
    logic                 advance;

    hrsp_pkg::phase_t     phase_reg, phase_next;
    logic [1:0]           digit_pos_reg, digit_pos_next;
    logic [7:0]           bytes_left_reg, bytes_left_next;
    logic [15:0]          load_addr_reg, load_addr_next;
    logic                 type_data_reg, type_data_next;
    logic [3:0]           high_nib_reg, high_nib_next;
    logic [15:0]          byte_total_reg, byte_total_next;
    logic                 halted_reg, halted_next;

    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_kind_reg, out_kind_next;
    logic [15:0]          out_addr_reg, out_addr_next;
    logic [7:0]           out_value_reg, out_value_next;
    logic [15:0]          out_total_reg, out_total_next;

    hrsp_pkg::hex_digit_t dig;
    logic                 res_valid;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_total_reg, out_value_reg, out_addr_reg};
    assign m_tuser  = out_kind_reg;

    assign dig = hrsp_pkg::hex_decode(in_char_reg);

    always_comb
    begin
        phase_next      = phase_reg;
        digit_pos_next  = digit_pos_reg;
        bytes_left_next = bytes_left_reg;
        load_addr_next  = load_addr_reg;
        type_data_next  = type_data_reg;
        high_nib_next   = high_nib_reg;
        byte_total_next = byte_total_reg;
        halted_next     = halted_reg;
        res_valid       = 1'b0;
        out_kind_next   = hrsp_pkg::KIND_ERROR;
        out_addr_next   = 16'd0;
        out_value_next  = 8'd0;

        if (advance && in_valid_reg && !halted_reg)
        begin
            if (phase_reg == hrsp_pkg::PH_COLON)
            begin
                if (in_char_reg != hrsp_pkg::CHAR_COLON)
                begin
                    halted_next = 1'b1;
                    res_valid   = 1'b1;
                end
                else
                begin
                    phase_next     = hrsp_pkg::PH_COUNT;
                    digit_pos_next = 2'd0;
                end
            end
            else if (phase_reg == hrsp_pkg::PH_SKIP)
            begin
                if (in_char_reg == hrsp_pkg::CHAR_NEWLINE)
                begin
                    phase_next = hrsp_pkg::PH_COLON;
                end
            end
            else if (!dig.ok)
            begin
                halted_next = 1'b1;
                res_valid   = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    hrsp_pkg::PH_COUNT:
                    begin
                        if (digit_pos_reg == 2'd0)
                        begin
                            high_nib_next  = dig.nib;
                            digit_pos_next = 2'd1;
                        end
                        else
                        begin
                            bytes_left_next = {high_nib_reg, dig.nib};
                            phase_next      = hrsp_pkg::PH_ADDR;
                            digit_pos_next  = 2'd0;
                        end
                    end
                    hrsp_pkg::PH_ADDR:
                    begin
                        load_addr_next = {load_addr_reg[11:0], dig.nib};
                        if (digit_pos_reg == 2'd3)
                        begin
                            phase_next     = hrsp_pkg::PH_TYPE;
                            digit_pos_next = 2'd0;
                        end
                        else
                        begin
                            digit_pos_next = digit_pos_reg + 2'd1;
                        end
                    end
                    hrsp_pkg::PH_TYPE:
                    begin
                        if (digit_pos_reg == 2'd0)
                        begin
                            type_data_next = (in_char_reg == hrsp_pkg::CHAR_ZERO);
                            digit_pos_next = 2'd1;
                        end
                        else
                        begin
                            type_data_next = type_data_reg
                                             && (in_char_reg == hrsp_pkg::CHAR_ZERO);
                            digit_pos_next = 2'd0;
                            if (!type_data_next)
                            begin
                                halted_next   = 1'b1;
                                res_valid     = 1'b1;
                                out_kind_next = hrsp_pkg::KIND_END;
                            end
                            else if (bytes_left_reg == 8'd0)
                            begin
                                phase_next = hrsp_pkg::PH_SKIP;
                            end
                            else
                            begin
                                phase_next = hrsp_pkg::PH_DATA;
                            end
                        end
                    end
                    hrsp_pkg::PH_DATA:
                    begin
                        if (digit_pos_reg == 2'd0)
                        begin
                            high_nib_next  = dig.nib;
                            digit_pos_next = 2'd1;
                        end
                        else
                        begin
                            digit_pos_next  = 2'd0;
                            res_valid       = 1'b1;
                            out_kind_next   = hrsp_pkg::KIND_DATA;
                            out_addr_next   = load_addr_reg;
                            out_value_next  = {high_nib_reg, dig.nib};
                            byte_total_next = byte_total_reg + 16'd1;
                            load_addr_next  = load_addr_reg + 16'd1;
                            bytes_left_next = bytes_left_reg - 8'd1;
                            if (bytes_left_next == 8'd0)
                            begin
                                phase_next = hrsp_pkg::PH_SKIP;
                            end
                        end
                    end
                    default:
                    begin
                        // colon and skip phases are handled above
                        phase_next  = hrsp_pkg::PH_COLON;
                        halted_next = 1'b1;
                        res_valid   = 1'b1;
                    end
                endcase
            end
        end

        out_total_next = byte_total_next;
        if (advance)
        begin
            out_valid_next = res_valid;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= hrsp_pkg::PH_COLON;
            digit_pos_reg  <= 2'd0;
            bytes_left_reg <= 8'd0;
            load_addr_reg  <= 16'd0;
            type_data_reg  <= 1'b1;
            high_nib_reg   <= 4'd0;
            byte_total_reg <= 16'd0;
            halted_reg     <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg  <= out_valid_next;
            phase_reg      <= phase_next;
            digit_pos_reg  <= digit_pos_next;
            bytes_left_reg <= bytes_left_next;
            load_addr_reg  <= load_addr_next;
            type_data_reg  <= type_data_next;
            high_nib_reg   <= high_nib_next;
            byte_total_reg <= byte_total_next;
            halted_reg     <= halted_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
        end
        if (advance && res_valid)
        begin
            out_kind_reg  <= out_kind_next;
            out_addr_reg  <= out_addr_next;
            out_value_reg <= out_value_next;
            out_total_reg <= out_total_next;
        end
    end

    // once halted, only reset leaves the halted state
    assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("parser left halted state without reset");

    // halting always comes with an end or error transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(halted_reg) |-> (m_tvalid && (m_tuser != hrsp_pkg::KIND_DATA)))
        else $error("halt without end or error result");

    // two-digit fields never count past the second digit
    assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == hrsp_pkg::PH_COUNT) || (phase_reg == hrsp_pkg::PH_TYPE)
         || (phase_reg == hrsp_pkg::PH_DATA)) |-> (digit_pos_reg[1] == 1'b0))
        else $error("digit position out of range");

    // data phase is entered and kept only while bytes remain
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == hrsp_pkg::PH_DATA) |-> (bytes_left_reg != 8'd0))
        else $error("data phase with no bytes left");

    // a data transfer carries a nonzero running total while the byte total register is nonzero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == hrsp_pkg::KIND_DATA) && (byte_total_reg != 16'd0))
        |-> (m_tdata[39:24] != 16'd0))
        else $error("data result with zero byte total");

endmodule
